@@ design/base57_block_encoder_unit_defines.svh @@
// assertion macros used by the base-57 encoder checker
`ifndef BASE57_BLOCK_ENCODER_UNIT_DEFINES_SVH
`define BASE57_BLOCK_ENCODER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define B57E_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define B57E_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/b57e_pkg.sv @@
// types, constants and tables of the base-57 block encoder
package b57e_pkg;

    localparam int BYTES_PER_GROUP  = 8;
    localparam int DIGITS_PER_GROUP = 11;
    localparam int RADIX            = 57;
    localparam int GROUP_BITS       = 64;
    localparam int DIGIT_W          = 6;
    localparam int NDIG_W           = 4;
    localparam int POS_W            = 3;
    localparam int CARRY_W          = 8;
    localparam int CHAR_W           = 7;
    localparam int PART_W           = DIGIT_W + CARRY_W;
    localparam int RECIP_W          = 15;
    localparam int PROD_W           = PART_W + RECIP_W;
    localparam int RECIP_SHIFT      = 20;

    // floor(x / 57) == (x * RECIP) >> RECIP_SHIFT for every x below 57 * 256
    localparam logic [RECIP_W-1:0] RECIP = 15'd18397;

    localparam int JOBQ_DEPTH  = 2;
    localparam int JOBQ_PTR_W  = $clog2(JOBQ_DEPTH);
    localparam int GRPQ_DEPTH  = 4;
    localparam int GRPQ_PTR_W  = $clog2(GRPQ_DEPTH);
    localparam int CREDIT_W    = $clog2(GRPQ_DEPTH + 1);

    localparam logic [NDIG_W-1:0] FULL_DIGITS = 4'd11;
    localparam logic [POS_W-1:0]  LAST_POS    = 3'd7;

    localparam logic [NDIG_W-1:0] TAIL_DIGITS [BYTES_PER_GROUP] =
        '{4'd0, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd9, 4'd10};

    // first character in the top byte
    localparam logic [RADIX-1:0][7:0] ALPHABET =
        "0123456789ACEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    typedef logic [DIGITS_PER_GROUP-1:0][DIGIT_W-1:0] digits_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } req_t;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              run_last;
        logic              message_last;
    } res_t;

    typedef struct packed {
        logic [GROUP_BITS-1:0] word;
        logic [NDIG_W-1:0]     ndig;
        logic                  fin;
    } job_t;

    typedef struct packed {
        logic               valid;
        logic               first;
        logic               last;
        logic [CARRY_W-1:0] carry;
        logic [NDIG_W-1:0]  ndig;
        logic               fin;
        digits_t            digits;
    } token_t;

    typedef struct packed {
        digits_t           digits;
        logic [NDIG_W-1:0] ndig;
        logic              fin;
    } group_t;

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [7:0] ch;
        ch = '0;
        if (d < DIGIT_W'(RADIX))
        begin
            ch = ALPHABET[RADIX - 1 - int'(d)];
        end
        return ch[CHAR_W-1:0];
    endfunction

endpackage

@@ design/b57e_front.sv @@
// front end: packs request bytes into groups and issues conversion jobs
module b57e_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  b57e_pkg::req_t request,
    output logic           job_push,
    output b57e_pkg::job_t job,
    input  logic           job_full
);
    import b57e_pkg::*;

    logic [GROUP_BITS-1:0] word_reg, word_next;
    logic [POS_W-1:0]      count_reg, count_next;
    logic [GROUP_BITS-1:0] word_merged;
    logic                  accept;
    logic                  close_group;

    assign full        = job_full;
    assign accept      = push && !job_full;
    assign close_group = (count_reg == LAST_POS) || request.final_byte;

    always_comb
    begin
        word_merged = word_reg;
        for (int k = 0; k < BYTES_PER_GROUP; k++)
        begin
            if (count_reg == POS_W'(k))
            begin
                word_merged[GROUP_BITS - CARRY_W * (k + 1) +: CARRY_W] = request.data_byte;
            end
        end
    end

    always_comb
    begin
        job.word = word_merged;
        job.ndig = (count_reg == LAST_POS) ? FULL_DIGITS : TAIL_DIGITS[count_reg + 1'b1];
        job.fin  = request.final_byte;
        job_push = accept && close_group;
    end

    always_comb
    begin
        word_next  = word_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (close_group)
            begin
                word_next  = '0;
                count_next = '0;
            end
            else
            begin
                word_next  = word_merged;
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            word_reg  <= word_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ design/b57e_job_queue.sv @@
// two-entry queue of conversion jobs between front and back end
module b57e_job_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  b57e_pkg::job_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output b57e_pkg::job_t rd_data,
    output logic           empty
);
    import b57e_pkg::*;

    job_t                mem_reg [JOBQ_DEPTH];
    logic [JOBQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [JOBQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [JOBQ_PTR_W:0]   count_reg, count_next;

    assign full    = (count_reg == (JOBQ_PTR_W + 1)'(JOBQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ design/b57e_cell.sv @@
// one base-57 digit cell of the systolic radix converter
module b57e_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  b57e_pkg::token_t tok_in,
    output b57e_pkg::token_t tok_out
);
    import b57e_pkg::*;

    logic [DIGIT_W-1:0] digit_reg;
    logic               valid_reg;
    token_t             tok_reg;
    token_t             tok_next;
    logic [DIGIT_W-1:0] base;
    logic [PART_W-1:0]  part;
    logic [PROD_W-1:0]  prod;
    logic [CARRY_W-1:0] quot;
    logic [PART_W-1:0]  quot_x57;
    logic [DIGIT_W-1:0] rem;

    // digit * 256 + carry, split into carry out and new digit
    always_comb
    begin
        base     = tok_in.first ? '0 : digit_reg;
        part     = {base, tok_in.carry};
        prod     = PROD_W'(part) * PROD_W'(RECIP);
        quot     = prod[RECIP_SHIFT +: CARRY_W];
        quot_x57 = (PART_W'(quot) << 6) - (PART_W'(quot) << 3) + PART_W'(quot);
        rem      = DIGIT_W'(part - quot_x57);
        tok_next        = tok_in;
        tok_next.carry  = quot;
        tok_next.digits = {tok_in.digits[DIGITS_PER_GROUP-2:0], rem};
    end

    always_ff @(posedge clk)
    begin
        if (tok_in.valid)
        begin
            digit_reg <= rem;
        end
        tok_reg <= tok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tok_in.valid;
        end
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = valid_reg;
    end

endmodule

@@ design/b57e_back.sv @@
// back end: byte feeder, digit cell row, group queue and character emitter
module b57e_back (
    input  logic           clk,
    input  logic           rst_n,
    input  b57e_pkg::job_t job,
    input  logic           job_empty,
    output logic           job_pop,
    output logic           empty,
    input  logic           pop,
    output b57e_pkg::res_t result
);
    import b57e_pkg::*;

    // feeder
    logic                  feed_busy_reg, feed_busy_next;
    logic [POS_W-1:0]      feed_pos_reg, feed_pos_next;
    job_t                  feed_job_reg, feed_job_next;
    logic [CREDIT_W-1:0]   inflight_reg, inflight_next;
    logic                  feed_done;
    logic                  start_job;
    token_t                feed_tok;
    token_t                tok_chain [DIGITS_PER_GROUP + 1];

    // group queue
    group_t                grp_reg [GRPQ_DEPTH];
    logic [GRPQ_PTR_W-1:0] grp_wr_ptr_reg, grp_wr_ptr_next;
    logic [GRPQ_PTR_W-1:0] grp_rd_ptr_reg, grp_rd_ptr_next;
    logic [GRPQ_PTR_W:0]   grp_count_reg, grp_count_next;
    logic                  grp_push;
    logic                  grp_pop;
    group_t                grp_head;

    // emitter
    logic [NDIG_W-1:0]     emit_idx_reg, emit_idx_next;
    logic                  out_valid_reg, out_valid_next;
    res_t                  out_data_reg, out_data_next;
    logic                  out_load;
    logic                  last_char;
    logic [DIGIT_W-1:0]    cur_digit;

    assign feed_done = feed_busy_reg && (feed_pos_reg == LAST_POS);
    assign start_job = !job_empty && (!feed_busy_reg || feed_done)
                       && (inflight_reg < CREDIT_W'(GRPQ_DEPTH));
    assign job_pop   = start_job;

    always_comb
    begin
        feed_tok        = '0;
        feed_tok.valid  = feed_busy_reg;
        feed_tok.first  = (feed_pos_reg == '0);
        feed_tok.last   = (feed_pos_reg == LAST_POS);
        feed_tok.carry  = feed_job_reg.word[GROUP_BITS-1 -: CARRY_W];
        feed_tok.ndig   = feed_job_reg.ndig;
        feed_tok.fin    = feed_job_reg.fin;
    end

    always_comb
    begin
        feed_busy_next = feed_busy_reg;
        feed_pos_next  = feed_pos_reg;
        feed_job_next  = feed_job_reg;
        if (start_job)
        begin
            feed_busy_next = 1'b1;
            feed_pos_next  = '0;
            feed_job_next  = job;
        end
        else if (feed_busy_reg)
        begin
            feed_pos_next      = feed_pos_reg + 1'b1;
            feed_job_next.word = feed_job_reg.word << CARRY_W;
            if (feed_done)
            begin
                feed_busy_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        inflight_next = inflight_reg;
        if (start_job && !grp_pop)
        begin
            inflight_next = inflight_reg + 1'b1;
        end
        else if (grp_pop && !start_job)
        begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    assign tok_chain[DIGITS_PER_GROUP] = feed_tok;

    for (genvar g = 0; g < DIGITS_PER_GROUP; g++)
    begin : g_cell
        b57e_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok_chain[g + 1]),
            .tok_out (tok_chain[g])
        );
    end

    assign grp_push = tok_chain[0].valid && tok_chain[0].last;
    assign grp_head = grp_reg[grp_rd_ptr_reg];

    always_comb
    begin
        grp_wr_ptr_next = grp_push ? grp_wr_ptr_reg + 1'b1 : grp_wr_ptr_reg;
        grp_rd_ptr_next = grp_pop ? grp_rd_ptr_reg + 1'b1 : grp_rd_ptr_reg;
        grp_count_next  = grp_count_reg;
        if (grp_push && !grp_pop)
        begin
            grp_count_next = grp_count_reg + 1'b1;
        end
        else if (grp_pop && !grp_push)
        begin
            grp_count_next = grp_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (grp_push)
        begin
            grp_reg[grp_wr_ptr_reg] <= '{digits: tok_chain[0].digits,
                                         ndig:   tok_chain[0].ndig,
                                         fin:    tok_chain[0].fin};
        end
    end

    assign cur_digit = grp_head.digits[emit_idx_reg];
    assign last_char = (NDIG_W'(emit_idx_reg + 1'b1) == grp_head.ndig);
    assign out_load  = (grp_count_reg != '0) && (!out_valid_reg || pop);
    assign grp_pop   = out_load && last_char;

    always_comb
    begin
        emit_idx_next  = emit_idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load)
        begin
            emit_idx_next              = last_char ? '0 : emit_idx_reg + 1'b1;
            out_valid_next             = 1'b1;
            out_data_next.digit_char   = digit_to_char(cur_digit);
            out_data_next.run_last     = last_char;
            out_data_next.message_last = last_char && grp_head.fin;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_data_reg;

    always_ff @(posedge clk)
    begin
        feed_job_reg <= feed_job_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feed_busy_reg  <= 1'b0;
            feed_pos_reg   <= '0;
            inflight_reg   <= '0;
            grp_wr_ptr_reg <= '0;
            grp_rd_ptr_reg <= '0;
            grp_count_reg  <= '0;
            emit_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            feed_busy_reg  <= feed_busy_next;
            feed_pos_reg   <= feed_pos_next;
            inflight_reg   <= inflight_next;
            grp_wr_ptr_reg <= grp_wr_ptr_next;
            grp_rd_ptr_reg <= grp_rd_ptr_next;
            grp_count_reg  <= grp_count_next;
            emit_idx_reg   <= emit_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule

@@ design/base57_block_encoder_unit.sv @@
// top level of the streaming base-57 block encoder
// Requests carry one message byte and an end-of-message flag; they enter on
// push/full and are taken at an edge with push high and full low.
// Characters leave on empty/pop: the oldest one sits on result while empty is
// low and is taken at an edge with pop high and empty low.
// Every eighth byte, or a flagged byte, closes a group; the group goes through
// a two-entry job queue to an eleven-cell systolic base-57 converter that
// takes one byte of the group per cycle (all eight bytes, zero padded).
// The first character of a group shows once the group has left the cell row
// for the group queue; the rest follow one per cycle while pop stays high.
// Requests are taken one per cycle while the job queue has room; sustained
// throughput is set by the character emitter, eleven characters per full group
// against eight bytes in; short final groups still pass eight bytes through.
// When pop stays low the output register holds its character, the converter
// stops after four finished groups and full rises once the job queue fills.
// Reset clears the open group and all queues; requests are taken right after.
module base57_block_encoder_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  b57e_pkg::req_t request,
    output logic           empty,
    input  logic           pop,
    output b57e_pkg::res_t result
);
    import b57e_pkg::*;

    logic job_push;
    job_t job_in;
    logic job_full;
    job_t job_head;
    logic job_empty;
    logic job_pop;

    b57e_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .request  (request),
        .job_push (job_push),
        .job      (job_in),
        .job_full (job_full)
    );

    b57e_job_queue u_job_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .full    (job_full),
        .rd_en   (job_pop),
        .rd_data (job_head),
        .empty   (job_empty)
    );

    b57e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_head),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

@@ design/b57e_checker.sv @@
// port-level assertions of the base-57 block encoder and their binding
`include "base57_block_encoder_unit_defines.svh"

module b57e_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           empty,
    input logic           pop,
    input b57e_pkg::res_t result
);
    import b57e_pkg::*;

    logic char_ok;

    assign char_ok = (result.digit_char >= 7'd48) && (result.digit_char <= 7'd122);

    `B57E_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(result), "result not held")
    `B57E_ASSERT_NEXT(a_run_continues, pop && !empty && !result.run_last, !empty, "run broken")
    `B57E_ASSERT_NOW(a_msg_ends_run, !empty && result.message_last, result.run_last, "bad end")
    `B57E_ASSERT_NOW(a_char_range, !empty, char_ok, "character out of alphabet range")

endmodule

bind base57_block_encoder_unit b57e_checker u_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
);

@@ dv/tb_base57_block_encoder_unit.sv @@
// testbench of the base-57 block encoder: directed table and random messages against a predictor
module tb_base57_block_encoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import b57e_pkg::*;

    localparam int N_ITEMS     = 460;
    localparam int MAX_REPORTS = 10;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 60;

    localparam int TAIL_LEN [BYTES_PER_GROUP] = '{0, 2, 3, 5, 6, 7, 9, 10};

    logic clk = 1'b0;
    logic rst_n;
    logic push;
    logic full;
    req_t request;
    logic empty;
    logic pop;
    res_t result;

    string b57_chars = "0123456789ACEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    logic [GROUP_BITS-1:0] open_word;
    int                    open_count;
    res_t                  pending_chars[$];
    int                    mismatches;
    int                    chars_seen;
    int                    sent;
    int                    burst_left;

    req_t  dir_req[$];
    string dir_typed[$];

    base57_block_encoder_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .request (request),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    always #5ns clk = ~clk;

    // expected characters of one request; a typed string replaces the computed ones
    function automatic void encode_request(input req_t r, input string typed);
        logic [GROUP_BITS-1:0] w;
        int                    held;
        int                    n;
        int                    j;
        int                    dig [DIGITS_PER_GROUP];
        res_t                  c;
        open_word = open_word | (GROUP_BITS'(r.data_byte) << (56 - 8 * open_count));
        held = open_count + 1;
        n = 0;
        if (held == BYTES_PER_GROUP)
        begin
            n = DIGITS_PER_GROUP;
        end
        else if (r.final_byte)
        begin
            n = TAIL_LEN[held];
        end
        if (n == 0)
        begin
            open_count = held;
            return;
        end
        w = open_word;
        for (j = DIGITS_PER_GROUP - 1; j >= 0; j--)
        begin
            dig[j] = int'(w % 64'd57);
            w = w / 64'd57;
        end
        if (typed.len() != 0)
        begin
            n = typed.len();
        end
        for (j = 0; j < n; j++)
        begin
            if (typed.len() != 0)
            begin
                c.digit_char = CHAR_W'(typed[j]);
            end
            else
            begin
                c.digit_char = CHAR_W'(b57_chars[dig[j]]);
            end
            c.run_last     = (j == n - 1);
            c.message_last = (j == n - 1) && r.final_byte;
            pending_chars.push_back(c);
        end
        open_word  = '0;
        open_count = 0;
    endfunction

    function automatic void add_row(input logic [7:0] b, input logic fin, input string typed);
        req_t r;
        r.data_byte  = b;
        r.final_byte = fin;
        dir_req.push_back(r);
        dir_typed.push_back(typed);
    endfunction

    task automatic send_request(input req_t r, input string typed);
        if (burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 20);
        end
        push    <= 1'b1;
        request <= r;
        @(posedge clk);
        while (full) @(posedge clk);
        encode_request(r, typed);
        sent++;
        burst_left--;
    endtask

    task automatic check_char(input res_t got);
        res_t want;
        if (pending_chars.size() == 0)
        begin
            if (mismatches < MAX_REPORTS)
            begin
                $display("unexpected character %h flags %b%b", got.digit_char, got.run_last,
                         got.message_last);
            end
            mismatches++;
            return;
        end
        want = pending_chars.pop_front();
        if (got.digit_char !== want.digit_char || got.run_last !== want.run_last ||
            got.message_last !== want.message_last)
        begin
            if (mismatches < MAX_REPORTS)
            begin
                $display("character %0d: expected %h/%b/%b got %h/%b/%b", chars_seen,
                         want.digit_char, want.run_last, want.message_last,
                         got.digit_char, got.run_last, got.message_last);
            end
            mismatches++;
        end
        chars_seen++;
    endtask

    // receiver: rotating stall patterns plus one long hold-off
    initial
    begin : receiver
        int  cycle_no;
        int  hold_left;
        bit  hold_done;
        int  mode;
        cycle_no  = 0;
        hold_left = 0;
        hold_done = 1'b0;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                check_char(result);
            end
            cycle_no++;
            mode = (cycle_no / 97) % 4;
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (!hold_done && chars_seen >= 80)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                pop <= 1'b0;
            end
            else if (mode == 0)
            begin
                pop <= 1'b1;
            end
            else if (mode == 1)
            begin
                pop <= 1'($urandom_range(0, 1));
            end
            else if (mode == 2)
            begin
                pop <= ($urandom_range(0, 4) != 0);
            end
            else
            begin
                pop <= ((cycle_no % 7) < 3);
            end
        end
    end

    initial
    begin : watchdog
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        req_t rq;
        int   i;
        int   k;
        int   len;
        int   kind;
        int   pick;
        rst_n      = 1'b0;
        push       = 1'b0;
        request    = '0;
        open_word  = '0;
        open_count = 0;
        mismatches = 0;
        chars_seen = 0;
        sent       = 0;
        burst_left = 0;

        add_row(8'h00, 1'b1, "00");
        for (i = 0; i < 7; i++)
        begin
            add_row(8'h00, 1'b0, "");
        end
        add_row(8'h00, 1'b0, "00000000000");
        add_row(8'hFF, 1'b1, "");
        add_row(8'hFF, 1'b0, "");
        add_row(8'hFF, 1'b1, "");
        add_row(8'h80, 1'b0, "");
        add_row(8'h01, 1'b0, "");
        add_row(8'h7F, 1'b1, "");
        for (i = 0; i < 7; i++)
        begin
            add_row(8'hFF, 1'b0, "");
        end
        add_row(8'hFF, 1'b1, "");
        add_row(8'hAA, 1'b0, "");
        add_row(8'h55, 1'b1, "");

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < dir_req.size(); i++)
        begin
            send_request(dir_req[i], dir_typed[i]);
        end

        while (sent < N_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 60)
            begin
                len = $urandom_range(1, 16);
            end
            else if (kind < 85)
            begin
                len = BYTES_PER_GROUP * $urandom_range(1, 3);
            end
            else
            begin
                len = $urandom_range(25, 60);
            end
            for (k = 0; k < len; k++)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                begin
                    rq.data_byte = 8'h00;
                end
                else if (pick == 1)
                begin
                    rq.data_byte = 8'hFF;
                end
                else
                begin
                    rq.data_byte = 8'($urandom);
                end
                rq.final_byte = (k == len - 1);
                send_request(rq, "");
            end
        end
        push <= 1'b0;

        while (pending_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0 && pending_chars.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ base57_block_encoder_unit.f @@
+incdir+design
design/b57e_pkg.sv
design/b57e_front.sv
design/b57e_job_queue.sv
design/b57e_cell.sv
design/b57e_back.sv
design/base57_block_encoder_unit.sv
design/b57e_checker.sv
dv/tb_base57_block_encoder_unit.sv
